/* design/fba_pkg.sv */
// ----------------------------------------------------------------------------
// File block allocator package
// Shared constants, status codes and the request payload type of the block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

   localparam int NUM_BLOCKS_DEF      = 128;
   localparam int MAX_FILES_DEF       = 16;
   localparam int MAX_FILE_BLOCKS_DEF = 8;

   localparam int BLOCK_NUMBER_W = 7;
   localparam int SIZE_W         = 4;
   localparam int INDEX_W        = 3;

   localparam logic [1:0] ACT_CREATE = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE    = 3'd1;
   localparam logic [2:0] ST_NO_BLOCKS   = 3'd2;
   localparam logic [2:0] ST_NAME_EXISTS = 3'd3;
   localparam logic [2:0] ST_NO_ENTRY    = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd5;
   localparam logic [2:0] ST_BEYOND      = 3'd6;

   // Request payload: action, name_high, name_low, file_blocks, block_index.
   typedef struct packed {
      logic [2:0]  block_index;
      logic [3:0]  file_blocks;
      logic [63:0] name_low;
      logic [63:0] name_high;
      logic [1:0]  action;
   } req_type;

endpackage

/* design/file_block_allocator.sv */
// ----------------------------------------------------------------------------
// File block allocator: free-block bitmap and file entry table under a sequencer.
// Create counts free blocks, scans the table and takes blocks; lookup scans the table
// and reads a pointer; delete scans it and frees the entry's pointers; a rejected
// request answers earlier. One request at a time; reset clears all but block 0.
// ----------------------------------------------------------------------------
module file_block_allocator #(
   parameter int NUM_BLOCKS      = fba_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_FILES       = fba_pkg::MAX_FILES_DEF,
   parameter int MAX_FILE_BLOCKS = fba_pkg::MAX_FILE_BLOCKS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[1:0], name_high[65:2], name_low[129:66], file_blocks[133:130],
   // block_index[136:134], zero fill to 144 bits
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], block_number[9:3], zero fill to 16 bits
   output logic [15:0]  rsp_tdata,
   output logic         rsp_tlast
);
   import fba_pkg::*;

   localparam int BW  = $clog2(NUM_BLOCKS);
   localparam int FW  = $clog2(MAX_FILES);
   localparam int PW  = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
   localparam int PTR = MAX_FILES * MAX_FILE_BLOCKS;
   localparam int PTW = $clog2(PTR);
   localparam int CW  = BW + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_COUNT = 3'd1;
   localparam logic [2:0] S_FIND  = 3'd2;
   localparam logic [2:0] S_ALLOC = 3'd3;
   localparam logic [2:0] S_FREE  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;
   localparam logic [2:0] S_PTRRD = 3'd6;
   localparam logic [2:0] S_WAIT  = 3'd7;

   // Storage
   logic [NUM_BLOCKS-1:0] in_use_ff;
   logic [MAX_FILES-1:0]  used_ff;
   logic [63:0]           name_hi_mem [MAX_FILES];
   logic [63:0]           name_lo_mem [MAX_FILES];
   logic [SIZE_W-1:0]     size_mem    [MAX_FILES];
   logic [BW-1:0]         ptr_mem     [PTR];
   logic [PTR-1:0]        ptr_valid_ff;

   logic [2:0]  state_ff;
   req_type     req_ff;
   logic [CW-1:0] bcnt_ff;
   logic [CW-1:0] free_ff;
   logic [FW:0]   ecnt_ff;
   logic          hit_ff, slot_ok_ff;
   logic [FW-1:0] hit_entry_ff, slot_ff;
   logic [PW:0]   k_ff;
   logic [BW-1:0] ptr_rd_ff;
   logic          ptr_rdv_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic [2:0]    rsp_st_ff;
   logic [6:0]    rsp_blk_ff;
   logic [2:0]    res_st_ff;
   logic [6:0]    res_blk_ff;

   logic [FW-1:0] eidx;
   logic          ematch;
   logic [PTW-1:0] paddr;

   assign eidx   = ecnt_ff[FW-1:0];
   assign ematch = used_ff[eidx] && name_hi_mem[eidx] == req_ff.name_high
                   && name_lo_mem[eidx] == req_ff.name_low;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_blk_ff, rsp_st_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Pointer address for the current entry and block position.
   always_comb begin
      paddr = PTW'(32'(state_ff == S_ALLOC ? slot_ff : hit_entry_ff) * MAX_FILE_BLOCKS
              + 32'(state_ff == S_PTRRD ? 32'(req_ff.block_index) : 32'(k_ff[PW-1:0])));
   end

   // Pointer memory, registered read.
   always_ff @(posedge clock) begin
      ptr_rd_ff  <= ptr_mem[paddr];
      ptr_rdv_ff <= ptr_valid_ff[paddr];
      if (state_ff == S_ALLOC && !in_use_ff[bcnt_ff[BW-1:0]] && !rsp_valid_ff)
         ptr_mem[paddr] <= bcnt_ff[BW-1:0];
   end

   // Name and size table writes on a successful create.
   always_ff @(posedge clock) begin
      if (state_ff == S_FIND && ecnt_ff == (FW+1)'(MAX_FILES) && !hit_ff && slot_ok_ff
          && req_ff.action == ACT_CREATE) begin
         name_hi_mem[slot_ff] <= req_ff.name_high;
         name_lo_mem[slot_ff] <= req_ff.name_low;
         size_mem[slot_ff]    <= req_ff.file_blocks;
      end
   end

   // Sequencer. Single-result answers are built in res_*_ff so that a response
   // still waiting at the output is never disturbed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= NUM_BLOCKS'(1);
         used_ff      <= '0;
         ptr_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  req_ff  <= req_type'(req_tdata[136:0]);
                  bcnt_ff <= CW'(1);
                  free_ff <= '0;
                  ecnt_ff <= '0;
                  hit_ff  <= 1'b0;
                  slot_ok_ff <= 1'b0;
                  k_ff    <= '0;
                  if (req_tdata[1:0] == ACT_CREATE) begin
                     if (req_tdata[133:130] == '0 ||
                         32'(req_tdata[133:130]) > MAX_FILE_BLOCKS) begin
                        res_st_ff <= ST_BAD_SIZE; state_ff <= S_RESP;
                     end else
                        state_ff <= S_COUNT;
                  end else if (req_tdata[1:0] == ACT_DELETE ||
                               req_tdata[1:0] == ACT_LOOKUP)
                     state_ff <= S_FIND;
               end
            end
            S_COUNT: begin
               if (bcnt_ff == CW'(NUM_BLOCKS)) begin
                  if (free_ff < CW'(req_ff.file_blocks)) begin
                     res_st_ff <= ST_NO_BLOCKS; state_ff <= S_RESP;
                  end else
                     state_ff <= S_FIND;
               end else begin
                  free_ff <= free_ff + CW'(!in_use_ff[bcnt_ff[BW-1:0]]);
                  bcnt_ff <= bcnt_ff + CW'(1);
               end
            end
            S_FIND: begin
               if (ecnt_ff == (FW+1)'(MAX_FILES)) begin
                  bcnt_ff <= CW'(1);
                  if (req_ff.action == ACT_CREATE) begin
                     if (hit_ff) begin
                        res_st_ff <= ST_NAME_EXISTS; state_ff <= S_RESP;
                     end else if (!slot_ok_ff) begin
                        res_st_ff <= ST_NO_ENTRY; state_ff <= S_RESP;
                     end else begin
                        used_ff[slot_ff] <= 1'b1;
                        state_ff <= S_ALLOC;
                     end
                  end else if (!hit_ff) begin
                     res_st_ff <= ST_NOT_FOUND; state_ff <= S_RESP;
                  end else if (req_ff.action == ACT_DELETE)
                     state_ff <= S_FREE;
                  else if (32'(req_ff.block_index) >= 32'(size_mem[hit_entry_ff]) ||
                           32'(req_ff.block_index) >= MAX_FILE_BLOCKS) begin
                     res_st_ff <= ST_BEYOND; state_ff <= S_RESP;
                  end else
                     state_ff <= S_PTRRD;
               end else begin
                  if (ematch && !hit_ff) begin
                     hit_ff <= 1'b1; hit_entry_ff <= eidx;
                  end
                  if (!used_ff[eidx] && !slot_ok_ff) begin
                     slot_ok_ff <= 1'b1; slot_ff <= eidx;
                  end
                  ecnt_ff <= ecnt_ff + (FW+1)'(1);
               end
            end
            S_ALLOC: begin
               // One block a cycle; a found block waits for the output slot.
               if (!in_use_ff[bcnt_ff[BW-1:0]]) begin
                  if (!rsp_valid_ff) begin
                     in_use_ff[bcnt_ff[BW-1:0]] <= 1'b1;
                     ptr_valid_ff[paddr] <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     rsp_st_ff    <= ST_OK;
                     rsp_blk_ff   <= 7'(bcnt_ff);
                     rsp_last_ff  <= (k_ff + (PW+1)'(1)) == (PW+1)'(req_ff.file_blocks);
                     k_ff         <= k_ff + (PW+1)'(1);
                     bcnt_ff      <= bcnt_ff + CW'(1);
                     if ((k_ff + (PW+1)'(1)) == (PW+1)'(req_ff.file_blocks))
                        state_ff <= S_IDLE;
                  end
               end else
                  bcnt_ff <= bcnt_ff + CW'(1);
            end
            S_FREE: begin
               // Read pointer k, then free it on the next cycle.
               if (bcnt_ff[0]) begin
                  bcnt_ff[0] <= 1'b0;
               end else begin
                  if (ptr_rdv_ff && ptr_rd_ff != '0)
                     in_use_ff[ptr_rd_ff] <= 1'b0;
                  ptr_valid_ff[paddr] <= 1'b0;
                  k_ff    <= k_ff + (PW+1)'(1);
                  bcnt_ff[0] <= 1'b1;
                  if (k_ff == (PW+1)'(MAX_FILE_BLOCKS - 1)) begin
                     used_ff[hit_entry_ff] <= 1'b0;
                     res_st_ff  <= ST_OK;
                     res_blk_ff <= 7'(size_mem[hit_entry_ff]);
                     state_ff   <= S_WAIT;
                  end
               end
            end
            S_PTRRD: begin
               if (bcnt_ff[0]) begin
                  bcnt_ff[0] <= 1'b0;
               end else begin
                  res_st_ff  <= ST_OK;
                  res_blk_ff <= ptr_rdv_ff ? 7'(ptr_rd_ff) : 7'd0;
                  state_ff   <= S_WAIT;
               end
            end
            S_RESP: begin
               res_blk_ff <= 7'd0;
               state_ff   <= S_WAIT;
            end
            S_WAIT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_st_ff    <= res_st_ff;
                  rsp_blk_ff   <= res_blk_ff;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* bench/file_block_allocator_tb.sv */
// ----------------------------------------------------------------------------
// File block allocator testbench
// Drives create, delete and lookup requests into the allocator, keeps its own
// model of the free-block bitmap and file table, and checks every response
// transaction against the predicted status, block number and last flag.
// ----------------------------------------------------------------------------
module file_block_allocator_tb;
   import fba_pkg::*;

   localparam int N_BLOCKS    = NUM_BLOCKS_DEF;
   localparam int N_FILES     = MAX_FILES_DEF;
   localparam int N_PTRS      = MAX_FILE_BLOCKS_DEF;
   localparam int N_RANDOM    = 440;
   localparam int N_NAMES     = 22;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] block_number;
      logic       last;
   } answer_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;
   logic         rsp_tlast;

   // Pending requests and the answers that the model expects.
   req_type    pending_reqs[$];
   answer_type expected_answers[$];
   int         n_requests;
   int         n_accepted;
   int         n_answers;
   int         n_errors;
   int         quiet_cycles;
   int         hold_left;
   bit         hold_done;
   bit         stimulus_ready;

   // Model state of the bitmap and the file table.
   bit          used_block[N_BLOCKS];
   bit          used_entry[N_FILES];
   logic [63:0] entry_hi[N_FILES];
   logic [63:0] entry_lo[N_FILES];
   logic [3:0]  entry_len[N_FILES];
   logic [6:0]  entry_ptr[N_FILES][N_PTRS];

   logic [63:0] name_pool_hi[N_NAMES];
   logic [63:0] name_pool_lo[N_NAMES];

   file_block_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock with a period of two time units.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic void push_answer(logic [2:0] st, logic [6:0] blk, logic lst);
      answer_type a;
      a.status       = st;
      a.block_number = blk;
      a.last         = lst;
      expected_answers.push_back(a);
   endfunction

   function automatic int find_file(logic [63:0] hi, logic [63:0] lo);
      for (int e = 0; e < N_FILES; e++)
         if (used_entry[e] && entry_hi[e] == hi && entry_lo[e] == lo)
            return e;
      return -1;
   endfunction

   // Works out the answers for one accepted request and updates the model.
   function automatic void allocate_and_answer(req_type r);
      int free_blocks;
      int e;
      int k;
      free_blocks = 0;
      e = find_file(r.name_high, r.name_low);
      k = 0;
      case (r.action)
         ACT_CREATE: begin
            for (int b = 1; b < N_BLOCKS; b++)
               if (!used_block[b]) free_blocks++;
            if (r.file_blocks < 1 || r.file_blocks > N_PTRS) begin
               push_answer(ST_BAD_SIZE, 7'd0, 1'b1);
            end else if (free_blocks < r.file_blocks) begin
               push_answer(ST_NO_BLOCKS, 7'd0, 1'b1);
            end else if (e >= 0) begin
               push_answer(ST_NAME_EXISTS, 7'd0, 1'b1);
            end else begin
               e = -1;
               for (int s = N_FILES - 1; s >= 0; s--)
                  if (!used_entry[s]) e = s;
               if (e < 0) begin
                  push_answer(ST_NO_ENTRY, 7'd0, 1'b1);
               end else begin
                  used_entry[e] = 1'b1;
                  entry_hi[e]   = r.name_high;
                  entry_lo[e]   = r.name_low;
                  entry_len[e]  = r.file_blocks;
                  for (int b = 1; b < N_BLOCKS && k < r.file_blocks; b++) begin
                     if (!used_block[b]) begin
                        used_block[b] = 1'b1;
                        entry_ptr[e][k] = b[6:0];
                        k++;
                        push_answer(ST_OK, b[6:0], k == r.file_blocks);
                     end
                  end
               end
            end
         end
         ACT_DELETE: begin
            if (e < 0) begin
               push_answer(ST_NOT_FOUND, 7'd0, 1'b1);
            end else begin
               for (int j = 0; j < N_PTRS; j++) begin
                  if (entry_ptr[e][j] != 0) used_block[entry_ptr[e][j]] = 1'b0;
                  entry_ptr[e][j] = 7'd0;
               end
               used_entry[e] = 1'b0;
               push_answer(ST_OK, {3'd0, entry_len[e]}, 1'b1);
            end
         end
         ACT_LOOKUP: begin
            if (e < 0)
               push_answer(ST_NOT_FOUND, 7'd0, 1'b1);
            else if (r.block_index >= entry_len[e])
               push_answer(ST_BEYOND, 7'd0, 1'b1);
            else
               push_answer(ST_OK, entry_ptr[e][r.block_index], 1'b1);
         end
         default: begin
            // The fourth action code is dropped without an answer.
         end
      endcase
   endfunction

   function automatic void queue_request(logic [1:0] act, logic [63:0] hi, logic [63:0] lo,
                                         logic [3:0] len, logic [2:0] idx);
      req_type r;
      r.action      = act;
      r.name_high   = hi;
      r.name_low    = lo;
      r.file_blocks = len;
      r.block_index = idx;
      pending_reqs.push_back(r);
      n_requests++;
   endfunction

   // Sender idles 7 in a hundred, then 67, then never.
   function automatic int sender_idle_pct();
      if (n_accepted < n_requests / 3) return 7;
      if (n_accepted < 2 * n_requests / 3) return 67;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (n_accepted < n_requests / 3) return 67;
      if (n_accepted < 2 * n_requests / 3) return 7;
      return 0;
   endfunction

   // Request driver: offers the next pending transaction once the last one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (stimulus_ready && pending_reqs.size() > 0 &&
             $urandom_range(99) >= sender_idle_pct()) begin
            req_tdata  <= {7'd0, pending_reqs.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver, with one long hold-off so that the allocator backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && n_accepted >= 90) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // Monitor: predicts on accepted requests and checks accepted responses.
   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            allocate_and_answer(req_type'(req_tdata[136:0]));
            n_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_answers++;
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected response status=%0d block=%0d last=%0b", $time,
                        rsp_tdata[2:0], rsp_tdata[9:3], rsp_tlast);
               n_errors++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tdata[2:0] != want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_tdata[2:0]);
                  n_errors++;
               end
               if (rsp_tdata[9:3] != want.block_number) begin
                  $display("%0t: block_number expected %0d actual %0d", $time,
                           want.block_number, rsp_tdata[9:3]);
                  n_errors++;
               end
               if (rsp_tlast != want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_tlast);
                  n_errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, expected_answers.size());
         $display("file_block_allocator_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int pick;
      int roll;
      logic [3:0] len;
      reset = 1'b1;
      n_requests = 0; n_accepted = 0; n_answers = 0; n_errors = 0;
      quiet_cycles = 0; hold_left = 0; hold_done = 0; stimulus_ready = 0;
      req_tvalid = 1'b0; req_tdata = '0; rsp_tready = 1'b0;
      used_block[0] = 1'b1;
      for (int b = 1; b < N_BLOCKS; b++) used_block[b] = 1'b0;
      for (int e = 0; e < N_FILES; e++) begin
         used_entry[e] = 1'b0; entry_hi[e] = '0; entry_lo[e] = '0; entry_len[e] = '0;
         for (int j = 0; j < N_PTRS; j++) entry_ptr[e][j] = '0;
      end
      name_pool_hi[0] = '0;  name_pool_lo[0] = '0;
      name_pool_hi[1] = '1;  name_pool_lo[1] = '1;
      for (int n = 2; n < N_NAMES; n++) begin
         name_pool_hi[n] = {$urandom, $urandom};
         name_pool_lo[n] = {$urandom, $urandom};
      end

      // Directed part: size limits, zero and all-ones names, four error statuses.
      queue_request(ACT_CREATE, 64'h1, 64'h2, 4'd0, 3'd0);
      queue_request(ACT_CREATE, 64'h1, 64'h2, 4'd9, 3'd0);
      queue_request(ACT_CREATE, 64'h1, 64'h2, 4'd15, 3'd0);
      queue_request(ACT_LOOKUP, '0, '0, 4'd0, 3'd0);
      queue_request(ACT_DELETE, '0, '0, 4'd0, 3'd0);
      queue_request(ACT_CREATE, '0, '0, 4'd1, 3'd0);
      queue_request(ACT_CREATE, '1, '1, 4'd8, 3'd0);
      queue_request(ACT_CREATE, '0, '0, 4'd2, 3'd0);
      queue_request(ACT_LOOKUP, '1, '1, 4'd0, 3'd7);
      queue_request(ACT_LOOKUP, '1, '1, 4'd0, 3'd0);
      queue_request(ACT_LOOKUP, '0, '0, 4'd0, 3'd1);
      queue_request(ACT_LOOKUP, '1, '0, 4'd0, 3'd0);
      queue_request(2'd3, '1, '1, 4'd15, 3'd7);
      queue_request(ACT_DELETE, '0, '0, 4'd0, 3'd0);
      queue_request(ACT_CREATE, 64'h5, '1, 4'd3, 3'd0);
      queue_request(ACT_LOOKUP, 64'h5, '1, 4'd0, 3'd2);
      queue_request(ACT_LOOKUP, 64'h5, '1, 4'd0, 3'd3);
      queue_request(ACT_DELETE, '1, '1, 4'd0, 3'd0);
      queue_request(ACT_DELETE, '1, '1, 4'd0, 3'd0);
      queue_request(ACT_DELETE, 64'h5, '1, 4'd0, 3'd0);

      // Random part over a small pool of names, so that files collide and the
      // table and the bitmap both run full now and then.
      for (int i = 0; i < N_RANDOM; i++) begin
         pick = $urandom_range(N_NAMES - 1);
         roll = $urandom_range(99);
         len  = ($urandom_range(99) < 88) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
         if (roll < 45)
            queue_request(ACT_CREATE, name_pool_hi[pick], name_pool_lo[pick], len,
                          3'($urandom_range(7)));
         else if (roll < 65)
            queue_request(ACT_DELETE, name_pool_hi[pick], name_pool_lo[pick], len,
                          3'($urandom_range(7)));
         else if (roll < 95)
            queue_request(ACT_LOOKUP, name_pool_hi[pick], name_pool_lo[pick], len,
                          3'($urandom_range(7)));
         else
            queue_request(2'd3, {$urandom, $urandom}, {$urandom, $urandom},
                          4'($urandom_range(15)), 3'($urandom_range(7)));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      stimulus_ready = 1'b1;

      wait (pending_reqs.size() == 0 && n_accepted == n_requests);
      wait (expected_answers.size() == 0);
      repeat (400) @(posedge clock);

      $display("Sent %0d requests (creates, deletes, lookups, ignored codes) under three",
               n_accepted);
      $display("idling mixes and one long response hold-off; checked %0d responses.",
               n_answers);
      if (n_errors == 0 && expected_answers.size() == 0)
         $display("file_block_allocator_tb: clean");
      else
         $display("file_block_allocator_tb: errors");
      $finish;
   end

endmodule
